// ===== design/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// shared types, constants and log2/exp2 tables for the stereo compressor
// ----------------------------------------------------------------------------
package spc_pkg;

	localparam int LOG_TB   = 8;                   // table index bits
	localparam int TAB_SIZE = (1 << LOG_TB) + 1;
	localparam int LOG_W    = 21;                  // log2 result, Q16, up to 24.0
	localparam int LOG_REM  = 23 - LOG_TB;         // interpolation bits of log2
	localparam int EXP_REM  = 16 - LOG_TB;         // interpolation bits of exp2
	localparam logic [16:0] UNITY = 17'd65536;

	typedef enum logic [1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_ATTACK    = 2'd1,
		CFG_RELEASE   = 2'd2,
		CFG_INV_RATIO = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [23:0] left_in;
		logic signed [23:0] right_in;
		logic               block_last;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] left_out;
		logic signed [23:0] right_out;
		logic [16:0]        gain_applied;
		logic               block_last_out;
	} out_item_t;

	// classified pair waiting for the back end
	typedef struct packed {
		logic signed [23:0] left;
		logic signed [23:0] right;
		logic [23:0]        peak;
		logic               last;
	} q_item_t;

	typedef struct packed {
		logic [22:0] thr;
		logic [16:0] atk;
		logic [16:0] rel;
		logic [16:0] ir;
	} cfg_t;

	typedef logic [16:0] tab_t [TAB_SIZE];

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] bt;
		logic [63:0] xv;
		r  = '0;
		bt = 64'h1 << 62;
		xv = x;
		for (int i = 0; i < 32; i++) begin
			if (bt > xv) bt = bt >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bt != 0) begin
				if (xv >= r + bt) begin
					xv = xv - (r + bt);
					r  = (r >> 1) + bt;
				end else begin
					r = r >> 1;
				end
				bt = bt >> 2;
			end
		end
		return r;
	endfunction

	// log2(1 + i/2^B) in Q16 by repeated squaring
	function automatic tab_t build_log_tab();
		tab_t        t;
		logic [63:0] z;
		logic [63:0] r;
		for (int i = 0; i < (1 << LOG_TB); i++) begin
			z = (64'h1 << 30) + (64'(i) << (30 - LOG_TB));
			r = '0;
			for (int k = 0; k < 17; k++) begin
				z = (z * z) >> 30;
				r = r << 1;
				if (z >= (64'h1 << 31)) begin
					z = z >> 1;
					r = r | 64'h1;
				end
			end
			t[i] = 17'((r + 64'h1) >> 1);
		end
		t[1 << LOG_TB] = UNITY;
		return t;
	endfunction

	// 2^-(i/2^B) in Q16 from repeated square roots of one half
	function automatic tab_t build_exp_tab();
		tab_t        t;
		logic [63:0] roots [LOG_TB + 1];
		logic [63:0] v;
		roots[0] = 64'h1 << 30;
		roots[1] = isqrt64(64'h1 << 59);
		for (int k = 2; k <= LOG_TB; k++)
			roots[k] = isqrt64(roots[k - 1] << 30);
		for (int i = 0; i < (1 << LOG_TB); i++) begin
			v = 64'h1 << 30;
			for (int j = 0; j < LOG_TB; j++) begin
				if (((i >> (LOG_TB - 1 - j)) & 1) != 0)
					v = (v * roots[j + 1]) >> 30;
			end
			t[i] = 17'((v + 64'd8192) >> 14);
		end
		t[1 << LOG_TB] = UNITY >> 1;
		return t;
	endfunction

	localparam tab_t LOG_TAB = build_log_tab();
	localparam tab_t EXP_TAB = build_exp_tab();

	function automatic logic [16:0] sat_unity(input logic [16:0] c);
		return (c > UNITY) ? UNITY : c;
	endfunction

endpackage

// ===== design/spc_front.sv =====
// ----------------------------------------------------------------------------
// spc_front
// takes stereo pairs, forms the linked peak and queues them for the back end
// ----------------------------------------------------------------------------
module spc_front
	import spc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_pop,
	output logic     q_valid,
	output q_item_t  q_head
);

	q_item_t     fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic [23:0] abs_l;
	logic [23:0] abs_r;
	q_item_t     item;

	always_comb begin
		abs_l = in_data.left_in[23] ? 24'(-in_data.left_in) : in_data.left_in;
		abs_r = in_data.right_in[23] ? 24'(-in_data.right_in) : in_data.right_in;
		item.left  = in_data.left_in;
		item.right = in_data.right_in;
		item.peak  = (abs_l > abs_r) ? abs_l : abs_r;
		item.last  = in_data.block_last;
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop) count_q <= count_q + 2'd1;
			else if (q_pop && !push) count_q <= count_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue overfilled");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule

// ===== design/spc_log2.sv =====
// ----------------------------------------------------------------------------
// spc_log2
// iterative log2 in Q16: five normalize steps, table lookup, interpolation
// ----------------------------------------------------------------------------
module spc_log2
	import spc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [23:0]      x,
	output logic             done,
	output logic [LOG_W-1:0] res
);

	typedef enum logic [1:0] {S_IDLE, S_NORM, S_LOOK, S_SUM} state_t;

	state_t               state_q;
	logic [2:0]           step_q;
	logic [23:0]          n_q;
	logic [4:0]           z_q;
	logic [16:0]          a_q;
	logic [16+LOG_REM:0]  prod_q;
	logic                 done_q;
	logic [LOG_W-1:0]     res_q;
	logic [LOG_TB:0]      idx;
	logic [16:0]          ta;
	logic [16:0]          tb;
	logic [4:0]           p;

	always_comb begin
		idx = {1'b0, n_q[22 -: LOG_TB]};
		ta  = LOG_TAB[idx];
		tb  = LOG_TAB[idx + 1'b1];
		p   = 5'd23 - z_q;
	end

	assign done = done_q;
	assign res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			n_q     <= '0;
			z_q     <= '0;
			a_q     <= '0;
			prod_q  <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q     <= x;
						z_q     <= '0;
						step_q  <= '0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd0: if (n_q[23:8] == '0) begin
							n_q <= n_q << 16; z_q <= z_q + 5'd16;
						end
						3'd1: if (n_q[23:16] == '0) begin
							n_q <= n_q << 8; z_q <= z_q + 5'd8;
						end
						3'd2: if (n_q[23:20] == '0) begin
							n_q <= n_q << 4; z_q <= z_q + 5'd4;
						end
						3'd3: if (n_q[23:22] == '0) begin
							n_q <= n_q << 2; z_q <= z_q + 5'd2;
						end
						3'd4: begin
							if (!n_q[23]) begin
								n_q <= n_q << 1; z_q <= z_q + 5'd1;
							end
							state_q <= S_LOOK;
						end
						default: state_q <= S_LOOK;
					endcase
				end
				S_LOOK: begin
					a_q     <= ta;
					prod_q  <= (tb - ta) * n_q[LOG_REM-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					res_q   <= LOG_W'({p, 16'd0}) + LOG_W'(a_q)
						+ LOG_W'(prod_q >> LOG_REM);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("log2 done held");
`endif

endmodule

// ===== design/spc_back.sv =====
// ----------------------------------------------------------------------------
// spc_back
// envelope follower, gain computation and sample scaling for one pair
// ----------------------------------------------------------------------------
module spc_back
	import spc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  q_item_t   q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_ENV_A, S_ENV_B, S_ENV_SUM, S_CMP, S_LOG,
		S_EXP_LOOK, S_EXP_FIN, S_SCALE, S_OUT
	} state_t;

	state_t             state_q;
	q_item_t            item_q;
	logic [16:0]        c_q;
	logic [40:0]        prod_a_q;
	logic [40:0]        prod_b_q;
	logic [23:0]        env_q;
	logic [21:0]        e_q;
	logic [16:0]        ea_q;
	logic [16+EXP_REM:0] ediff_q;
	logic [5:0]         en_q;
	logic [16:0]        gain_q;
	logic signed [41:0] lp_q;
	logic signed [41:0] rp_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [22:0]        t_eff;
	logic               log_start;
	logic               le_done;
	logic               lt_done;
	logic [LOG_W-1:0]   le;
	logic [LOG_W-1:0]   lt;
	logic signed [LOG_W:0] d;
	logic [LOG_W-1:0]   d_pos;
	logic [LOG_W+16:0]  e_full;
	logic [LOG_TB:0]    eidx;
	logic [16:0]        eta;
	logic [16:0]        etb;
	logic [16:0]        v;
	logic               out_free;

	assign t_eff     = (cfg.thr == '0) ? 23'd1 : cfg.thr;
	assign log_start = (state_q == S_CMP) && (env_q > {1'b0, t_eff});
	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	spc_log2 u_log_env (
		.clk, .arst_n, .start(log_start), .x(env_q), .done(le_done), .res(le)
	);
	spc_log2 u_log_thr (
		.clk, .arst_n, .start(log_start), .x({1'b0, t_eff}), .done(lt_done), .res(lt)
	);

	always_comb begin
		d      = $signed({1'b0, le}) - $signed({1'b0, lt});
		d_pos  = d[LOG_W] ? '0 : d[LOG_W-1:0];
		e_full = d_pos * (UNITY - sat_unity(cfg.ir));
		eidx   = {1'b0, e_q[15 -: LOG_TB]};
		eta    = EXP_TAB[eidx];
		etb    = EXP_TAB[eidx + 1'b1];
		v      = ea_q - 17'(ediff_q >> EXP_REM);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (q_valid) begin
				item_q <= q_head;
				c_q    <= sat_unity((q_head.peak > env_q) ? cfg.atk : cfg.rel);
			end
			S_ENV_A: prod_a_q <= 41'(item_q.peak * c_q);
			S_ENV_B: prod_b_q <= 41'(env_q * (UNITY - c_q));
			S_LOG: e_q <= e_full[LOG_W+16:16];
			S_EXP_LOOK: begin
				ea_q    <= eta;
				ediff_q <= (eta - etb) * e_q[EXP_REM-1:0];
				en_q    <= e_q[21:16];
			end
			S_SCALE: begin
				lp_q <= item_q.left * $signed({1'b0, gain_q});
				rp_q <= item_q.right * $signed({1'b0, gain_q});
			end
			S_OUT: if (out_free) begin
				out_q.left_out       <= lp_q[39:16];
				out_q.right_out      <= rp_q[39:16];
				out_q.gain_applied   <= gain_q;
				out_q.block_last_out <= item_q.last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			env_q       <= '0;
			gain_q      <= UNITY;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load on a free slot, clear once taken
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:    if (q_valid) state_q <= S_ENV_A;
				S_ENV_A:   state_q <= S_ENV_B;
				S_ENV_B:   state_q <= S_ENV_SUM;
				S_ENV_SUM: begin
					env_q   <= 24'((prod_a_q + prod_b_q) >> 16);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (log_start) begin
						state_q <= S_LOG;
					end else begin
						gain_q  <= UNITY;
						state_q <= S_SCALE;
					end
				end
				S_LOG:      if (le_done && lt_done) state_q <= S_EXP_LOOK;
				S_EXP_LOOK: state_q <= S_EXP_FIN;
				S_EXP_FIN: begin
					gain_q  <= (en_q >= 6'd17) ? '0 : (v >> en_q);
					state_q <= S_SCALE;
				end
				S_SCALE: state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= 24'd8388608) else $error("envelope out of range");
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.gain_applied <= UNITY) else $error("gain above unity");
	a_log_pair: assert property (@(posedge clk) disable iff (!arst_n)
		le_done == lt_done) else $error("log units out of step");
`endif

endmodule

// ===== design/stereo_peak_compressor.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_compressor
// stereo linked peak compressor with table based log2/exp2 gain
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid/in_stall carry one stereo pair request (in_data);
//   a request is taken when in_valid is high and in_stall low. the front end
//   forms the linked peak and parks the pair in a two entry queue.
//   out channel: out_valid/out_stall carry one result per pair, in order,
//   held steady while out_stall is high.
//   cfg channel: cfg_valid/cfg_ready, always ready; write only while idle.
// sequencing
//   below threshold a pair goes from queue head straight to scaling and the
//   output register; above it the pair also waits on the two log2 units (five
//   normalize steps each, run side by side) and the exp2 interpolation step.
//   the back end takes the next pair only once the output register has
//   accepted the last one, so it works on one pair at a time.
// stall and reset
//   a stalled output holds; the back end waits in its last step and the
//   queue absorbs two more pairs before in_stall rises.
//   reset clears envelope to zero, loads register defaults, empties queue.
// ----------------------------------------------------------------------------
module stereo_peak_compressor
	import spc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	cfg_t    cfg_q;
	logic    q_valid;
	logic    q_pop;
	q_item_t q_head;

	// register file, a write lands in its register at the next clock edge
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr <= 23'd4194304;
			cfg_q.atk <= 17'd6554;
			cfg_q.rel <= 17'd66;
			cfg_q.ir  <= 17'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THRESHOLD: cfg_q.thr <= cfg_data;
				CFG_ATTACK:    cfg_q.atk <= cfg_data[16:0];
				CFG_RELEASE:   cfg_q.rel <= cfg_data[16:0];
				CFG_INV_RATIO: cfg_q.ir  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// front end: peak detect and queue
	spc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_pop, .q_valid, .q_head
	);

	// back end: envelope, gain and scaling sequencer with output register
	spc_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_head, .q_pop,
		.out_valid, .out_stall, .out_data
	);

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stereo linked peak compressor: a queue-fed
// driver offers stereo pair requests, a monitor predicts each result at
// acceptance and compares every output field in order, across several
// register settings including the extremes
// ----------------------------------------------------------------------------
module tb;
	import spc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [22:0] cfg_data = '0;

	stereo_peak_compressor uut (.*);

	always #1 clk = ~clk;

	// predictor state and register copies
	logic [23:0] env_q;
	logic [22:0] thr_q;
	logic [16:0] atk_q, rel_q, ir_q;
	longint unsigned log_lut [TAB_SIZE];
	longint unsigned exp_lut [TAB_SIZE];

	in_item_t  pending_pairs [$];
	out_item_t expected_out [$];
	int        mismatches = 0;
	int        accepted = 0;
	bit        quiet = 1'b0;

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r, b, v;
		r = 0;
		b = 64'h1 << 62;
		v = x;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 fractions by repeated squaring, exp2 by chained roots of one half
	task automatic make_luts();
		longint unsigned rt [LOG_TB + 1];
		longint unsigned z, r, v;
		rt[0] = 64'h1 << 30;
		rt[1] = int_sqrt(64'h1 << 59);
		for (int k = 2; k <= LOG_TB; k++) rt[k] = int_sqrt(rt[k - 1] << 30);
		for (int i = 0; i < (1 << LOG_TB); i++) begin
			z = (64'h1 << 30) + (longint'(i) << (30 - LOG_TB));
			r = 0;
			for (int k = 0; k < 17; k++) begin
				z = (z * z) >> 30;
				r = r << 1;
				if (z >= (64'h1 << 31)) begin
					z = z >> 1;
					r = r | 1;
				end
			end
			log_lut[i] = (r + 1) >> 1;
			v = 64'h1 << 30;
			for (int j = 0; j < LOG_TB; j++)
				if (((i >> (LOG_TB - 1 - j)) & 1) != 0) v = (v * rt[j + 1]) >> 30;
			exp_lut[i] = (v + 8192) >> 14;
		end
		log_lut[1 << LOG_TB] = 65536;
		exp_lut[1 << LOG_TB] = 32768;
	endtask

	function automatic longint unsigned log2_fix(input longint unsigned x);
		longint unsigned p, f, idx, rem, a, b;
		p = 0;
		while (p < 23 && (x >> (p + 1)) != 0) p++;
		f = (x << (23 - p)) & 64'h7FFFFF;
		idx = f >> LOG_REM;
		rem = f & ((64'h1 << LOG_REM) - 1);
		a = log_lut[idx];
		b = log_lut[idx + 1];
		return p * 65536 + a + (((b - a) * rem) >> LOG_REM);
	endfunction

	function automatic longint unsigned exp2_neg(input longint unsigned e);
		longint unsigned n, fr, idx, rem, a, b, v;
		n = e >> 16;
		fr = e & 64'hFFFF;
		idx = fr >> EXP_REM;
		rem = fr & ((64'h1 << EXP_REM) - 1);
		a = exp_lut[idx];
		b = exp_lut[idx + 1];
		if (n >= 17) return 0;
		v = a - (((a - b) * rem) >> EXP_REM);
		return v >> n;
	endfunction

	function automatic longint unsigned clip_unity(input logic [16:0] c);
		return (c > 17'd65536) ? 65536 : longint'(c);
	endfunction

	function automatic logic [23:0] apply_gain(input logic signed [23:0] s,
			input longint unsigned g);
		longint p;
		p = longint'(s) * longint'(g);
		return 24'(p >>> 16);
	endfunction

	// advances the envelope and returns the expected result for one pair
	function automatic out_item_t compress_pair(input in_item_t it);
		longint unsigned al, ar, pk, c, t, g, lg_e, lg_t, d;
		out_item_t o;
		al = it.left_in < 0 ? longint'(-longint'(it.left_in)) : longint'(it.left_in);
		ar = it.right_in < 0 ? longint'(-longint'(it.right_in)) : longint'(it.right_in);
		pk = al > ar ? al : ar;
		t = (thr_q == 0) ? 1 : longint'(thr_q);
		c = clip_unity(pk > env_q ? atk_q : rel_q);
		env_q = 24'((pk * c + longint'(env_q) * (65536 - c)) >> 16);
		g = 65536;
		if (env_q > t) begin
			lg_e = log2_fix(env_q);
			lg_t = log2_fix(t);
			d = lg_e > lg_t ? lg_e - lg_t : 0;
			g = exp2_neg((d * (65536 - clip_unity(ir_q))) >> 16);
		end
		o.left_out = apply_gain(it.left_in, g);
		o.right_out = apply_gain(it.right_in, g);
		o.gain_applied = 17'(g);
		o.block_last_out = it.block_last;
		return o;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("error: %s got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// driver: next request goes out once the current one is taken
	int gap_left = 0;
	always @(posedge clk) begin
		if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (pending_pairs.size() != 0) begin
				in_data <= pending_pairs.pop_front();
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver stall: random bursts plus one long hold-off to back the block up
	int stall_left = 0;
	int hold_left = 0;
	bit held_once = 1'b0;
	always @(posedge clk) begin
		if (!held_once && accepted >= 300) begin
			held_once <= 1'b1;
			hold_left <= 250;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (quiet)
			out_stall <= 1'b0;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// monitor: predict at request acceptance, compare at result acceptance
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && in_valid && !in_stall) begin
			expected_out.push_back(compress_pair(in_data));
			accepted <= accepted + 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out.size() == 0)
				report("unexpected result, left_out", out_data.left_out, 0);
			else begin
				w = expected_out.pop_front();
				if (out_data.left_out !== w.left_out)
					report("left_out", out_data.left_out, w.left_out);
				if (out_data.right_out !== w.right_out)
					report("right_out", out_data.right_out, w.right_out);
				if (out_data.gain_applied !== w.gain_applied)
					report("gain_applied", out_data.gain_applied, w.gain_applied);
				if (out_data.block_last_out !== w.block_last_out)
					report("block_last_out", out_data.block_last_out, w.block_last_out);
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [22:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_THRESHOLD: thr_q = val;
			CFG_ATTACK:    atk_q = val[16:0];
			CFG_RELEASE:   rel_q = val[16:0];
			CFG_INV_RATIO: ir_q = val[16:0];
			default: ;
		endcase
	endtask

	task automatic push_pair(input logic signed [23:0] l, input logic signed [23:0] r,
			input logic last);
		in_item_t it;
		it.left_in = l;
		it.right_in = r;
		it.block_last = last;
		pending_pairs.push_back(it);
	endtask

	function automatic logic signed [23:0] random_sample();
		logic signed [23:0] s;
		s = 24'($urandom);
		case ($urandom_range(0, 4))
			0, 1: ;
			2: s = s >>> $urandom_range(3, 20);
			3: s = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: s = 24'($signed($urandom_range(0, 2)) - 1);
		endcase
		return s;
	endfunction

	task automatic random_pairs(input int n);
		logic signed [23:0] l;
		for (int i = 0; i < n; i++) begin
			l = random_sample();
			// mostly correlated stereo, sometimes independent channels
			push_pair(l, $urandom_range(0, 2) == 0 ? random_sample() : l >>> $urandom_range(0, 3),
				1'($urandom));
		end
	endtask

	// sender pause: wait until every request is out and every result is back
	task automatic drain();
		do @(negedge clk);
		while (pending_pairs.size() != 0 || in_valid || expected_out.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		make_luts();
		env_q = '0;
		thr_q = 23'd4194304;
		atk_q = 17'd6554;
		rel_q = 17'd66;
		ir_q = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, envelope climbing past the default knee
		push_pair(24'sd0, 24'sd0, 1'b0);
		push_pair(24'sd1, -24'sd1, 1'b1);
		for (int i = 0; i < 12; i++)
			push_pair(24'sh7FFFFF, 24'sh800000, 1'(i));
		push_pair(24'sh800000, 24'sh800000, 1'b1);
		push_pair(24'sh7FFFFF, 24'sd0, 1'b0);
		push_pair(24'sd0, 24'sh800000, 1'b1);
		push_pair(24'sh400000, -24'sh400000, 1'b0);
		push_pair(24'sd0, 24'sd0, 1'b1);
		push_pair(-24'sd1, 24'sd12345, 1'b0);
		drain();

		// lowest knee, instant attack, frozen release, hard limiting
		write_reg(CFG_THRESHOLD, 23'd1);
		write_reg(CFG_ATTACK, 23'd65536);
		write_reg(CFG_RELEASE, 23'd0);
		write_reg(CFG_INV_RATIO, 23'd0);
		random_pairs(350);
		drain();

		// highest knee, over-unity coefficients saturate, ratio one
		write_reg(CFG_THRESHOLD, 23'h7FFFFF);
		write_reg(CFG_ATTACK, 23'h1FFFF);
		write_reg(CFG_RELEASE, 23'h1FFFF);
		write_reg(CFG_INV_RATIO, 23'd65536);
		random_pairs(200);
		drain();

		// zero knee acts as one, over-unity ratio
		write_reg(CFG_THRESHOLD, 23'd0);
		write_reg(CFG_ATTACK, 23'd1000);
		write_reg(CFG_RELEASE, 23'd30000);
		write_reg(CFG_INV_RATIO, 23'h1FFFF);
		random_pairs(250);
		drain();

		write_reg(CFG_THRESHOLD, 23'd1 << 20);
		write_reg(CFG_ATTACK, 23'd6554);
		write_reg(CFG_RELEASE, 23'd66);
		write_reg(CFG_INV_RATIO, 23'd32768);
		random_pairs(500);
		drain();

		// final stretch at full rate, random settings
		write_reg(CFG_THRESHOLD, 23'($urandom_range(1, 23'h7FFFFF)));
		write_reg(CFG_ATTACK, 23'($urandom_range(0, 65536)));
		write_reg(CFG_RELEASE, 23'($urandom_range(0, 65536)));
		write_reg(CFG_INV_RATIO, 23'($urandom_range(0, 65536)));
		quiet = 1'b1;
		random_pairs(400);
		drain();

		if (mismatches == 0)
			$display("stereo_peak_compressor: match");
		else
			$display("stereo_peak_compressor: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("stereo_peak_compressor: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/spc_pkg.sv
design/spc_front.sv
design/spc_log2.sv
design/spc_back.sv
design/stereo_peak_compressor.sv
verif/tb.sv
